// ----- rtl/dicd_pkg.sv -----
// dicd_pkg: item types, opcode and result-kind codes, channel limits and the
// command/status structs shared by the change detector modules.
// No dependencies.
`default_nettype none

package dicd_pkg;

  // input item: one update or read request
  typedef struct packed {
    logic [2:0]  opcode;
    logic [12:0] channel;
    logic [31:0] new_bits;
  } in_item_t;

  // result item: change event, read reply or error
  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] event_channel;
    logic        bit_value;
    logic        last;
  } out_item_t;

  // opcodes
  localparam logic [2:0] OP_WR8  = 3'd0;
  localparam logic [2:0] OP_WR1  = 3'd1;
  localparam logic [2:0] OP_WR16 = 3'd2;
  localparam logic [2:0] OP_WR32 = 3'd3;
  localparam logic [2:0] OP_RD   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;
  localparam logic [1:0] KIND_ALIGN = 2'd3;

  // highest legal channel per access type, before the image size cap
  localparam logic [13:0] LIMIT_WR8  = 14'd2032;
  localparam logic [13:0] LIMIT_WR1  = 14'd1024;
  localparam logic [13:0] LIMIT_WR16 = 14'd4064;
  localparam logic [13:0] LIMIT_WR32 = 14'd8128;
  localparam logic [13:0] LIMIT_RD   = 14'd8128;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted item
    logic look;    // check the channel, read the image word
    logic apply;   // merge and write back, or answer read/error
    logic emit;    // send the next change event
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_bad;     // unused opcode, item is dropped
    logic single;     // item answers with exactly one result
    logic no_change;  // write flipped no channel
    logic emit_done;  // the event being sent is the final one
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/dicd_ctrl.sv -----
// dicd_ctrl: sequencing state machine for the change detector.
// Depends on dicd_pkg for the command and status structs.
`default_nettype none

module dicd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire dicd_pkg::dp_sts_t sts,
  output dicd_pkg::ctl_cmd_t   cmd
);
  import dicd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = sts.op_bad ? S_IDLE : S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = (sts.single || sts.no_change) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/dicd_datapath.sv -----
// dicd_datapath: item register, channel checks, input image memory with
// per-word valid bits, change mask and event scanner, result register.
// Depends on dicd_pkg for item types, codes and limits.
`default_nettype none

module dicd_datapath #(
  parameter int IMAGE_WORDS = 254
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire dicd_pkg::in_item_t in_item,
  input  wire dicd_pkg::ctl_cmd_t cmd,
  output dicd_pkg::dp_sts_t    sts,
  output logic                 out_valid,
  output dicd_pkg::out_item_t  out_item
);
  import dicd_pkg::*;

  localparam int          WORD_W = (IMAGE_WORDS > 1) ? $clog2(IMAGE_WORDS) : 1;
  localparam logic [13:0] CAP    = 14'(32 * IMAGE_WORDS);

  // item and working registers
  in_item_t    item_r;
  logic [31:0] rd_r;
  logic        rd_vld_r;
  logic        err_r;
  logic [1:0]  err_kind_r;
  logic [31:0] chg_r;
  logic [31:0] chg_nxt;
  logic [31:0] val_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;

  // image store; a word not yet written reads as zeros
  logic [31:0]            mem [IMAGE_WORDS];
  logic [IMAGE_WORDS-1:0] vld_r;

  // decode
  logic [13:0]       lim_base;
  logic [13:0]       limit;
  logic [31:0]       fmask;
  logic              align_bad;
  logic              range_bad;
  logic [12:0]       chm1;
  logic [4:0]        sh;
  logic [WORD_W-1:0] widx;
  logic              is_write;
  logic              is_read;

  assign chm1     = item_r.channel - 13'd1;
  assign sh       = chm1[4:0];
  assign widx     = chm1[WORD_W+4:5];
  assign is_write = (item_r.opcode == OP_WR8) || (item_r.opcode == OP_WR1) ||
                    (item_r.opcode == OP_WR16) || (item_r.opcode == OP_WR32);
  assign is_read  = (item_r.opcode == OP_RD);

  always_comb begin
    case (item_r.opcode)
      OP_WR8: begin
        lim_base  = LIMIT_WR8;
        fmask     = 32'h0000_00ff;
        align_bad = (chm1[2:0] != 3'd0);
      end
      OP_WR1: begin
        lim_base  = LIMIT_WR1;
        fmask     = 32'h0000_0001;
        align_bad = 1'b0;
      end
      OP_WR16: begin
        lim_base  = LIMIT_WR16;
        fmask     = 32'h0000_ffff;
        align_bad = (chm1[3:0] != 4'd0);
      end
      OP_WR32: begin
        lim_base  = LIMIT_WR32;
        fmask     = 32'hffff_ffff;
        align_bad = (chm1[4:0] != 5'd0);
      end
      default: begin
        lim_base  = LIMIT_RD;
        fmask     = 32'h0000_0001;
        align_bad = 1'b0;
      end
    endcase
  end

  assign limit     = (lim_base > CAP) ? CAP : lim_base;
  assign range_bad = (item_r.channel == 13'd0) || ({1'b0, item_r.channel} > limit);

  // merge of the new bits into the current word
  logic [31:0] cur_word;
  logic [31:0] cur_shift;
  logic [31:0] new_val;
  logic [31:0] chg_now;
  logic [31:0] new_word;

  assign cur_word  = rd_vld_r ? rd_r : 32'd0;
  assign cur_shift = cur_word >> sh;
  assign new_val   = item_r.new_bits & fmask;
  assign chg_now   = (cur_shift & fmask) ^ new_val;
  assign new_word  = (cur_word & ~(fmask << sh)) | (new_val << sh);

  // lowest pending change and what remains after it
  logic [4:0]  first_k;
  logic [31:0] chg_rest;

  always_comb begin
    first_k = 5'd0;
    for (int k = 31; k >= 0; k--) begin
      if (chg_r[k]) begin
        first_k = 5'(k);
      end
    end
  end

  assign chg_rest = chg_r & (chg_r - 32'd1);

  // item capture and checks
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.look) begin
      err_r      <= range_bad || align_bad;
      err_kind_r <= range_bad ? KIND_RANGE : KIND_ALIGN;
      rd_vld_r   <= vld_r[widx];
    end
  end

  // image memory read and write-back
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      rd_r <= mem[widx];
    end
    if (cmd.apply && !err_r && is_write) begin
      mem[widx] <= new_word;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.apply && !err_r && is_write) begin
      vld_r[widx] <= 1'b1;
    end
  end

  // result selection and change mask update
  always_comb begin
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    chg_nxt       = chg_r;
    if (cmd.apply) begin
      chg_nxt = chg_now;
      if (err_r) begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.kind          = err_kind_r;
        out_item_nxt.event_channel = 13'd0;
        out_item_nxt.bit_value     = 1'b0;
        out_item_nxt.last          = 1'b1;
      end else if (is_read) begin
        out_valid_nxt              = 1'b1;
        out_item_nxt.kind          = KIND_READ;
        out_item_nxt.event_channel = item_r.channel;
        out_item_nxt.bit_value     = cur_shift[0];
        out_item_nxt.last          = 1'b1;
      end
    end else if (cmd.emit) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.kind          = KIND_EVENT;
      out_item_nxt.event_channel = item_r.channel + 13'(first_k);
      out_item_nxt.bit_value     = val_r[first_k];
      out_item_nxt.last          = (chg_rest == 32'd0);
      chg_nxt                    = chg_rest;
    end
  end

  always_ff @(posedge clk) begin
    chg_r      <= chg_nxt;
    out_item_r <= out_item_nxt;
    if (cmd.apply) begin
      val_r <= new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // status to the controller
  assign sts.op_bad    = !is_write && !is_read;
  assign sts.single    = err_r || is_read;
  assign sts.no_change = (chg_now == 32'd0);
  assign sts.emit_done = (chg_rest == 32'd0);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/digital_input_change_detector.sv -----
// digital_input_change_detector: top level, controller plus datapath.
// Depends on dicd_pkg, dicd_ctrl and dicd_datapath.
//
// An item is taken when start is high and busy is low. A read, an error
// or a write that flips nothing passes through a look and an apply state,
// a write that flips channels also through an emit state that sends its
// events; busy stays high until the item is done. This follows from the
// single-port image memory (read in look, merged and written back in
// apply) and the event scanner, which sends one change event per cycle in
// ascending channel order. Each result is shown for one cycle with
// out_valid high and cannot be held off, so the receiver must take it
// then. The image is all zeros after reset with no clearing pass.
`default_nettype none

module digital_input_change_detector #(
  parameter int IMAGE_WORDS = 254
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire dicd_pkg::in_item_t in_item,
  output logic                 out_valid,
  output dicd_pkg::out_item_t  out_item
);
  import dicd_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencing
  dicd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // image, checks and event generation
  dicd_datapath #(
    .IMAGE_WORDS (IMAGE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- rtl/dicd_checker.sv -----
// dicd_checker: port-level checks for the change detector, bound to the top.
// Depends on dicd_pkg for item types and result kinds.
`default_nettype none

module dicd_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input wire dicd_pkg::in_item_t  in_item,
  input wire                  out_valid,
  input wire dicd_pkg::out_item_t out_item
);
  import dicd_pkg::*;

  // an accepted item makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // no result in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result right after accept");

  // error results carry no channel and close the item
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.kind == KIND_RANGE || out_item.kind == KIND_ALIGN)) |->
    (out_item.last && out_item.event_channel == 13'd0 && !out_item.bit_value))
    else $error("malformed error result");

  // only change events may be followed by more results
  a_nonlast_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> (out_item.kind == KIND_EVENT))
    else $error("non-final result that is not a change event");

  // events of one item come back to back
  a_event_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |=> (out_valid && out_item.kind == KIND_EVENT))
    else $error("gap inside an event burst");

endmodule

bind digital_input_change_detector dicd_checker u_dicd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for digital_input_change_detector. A directed
// table, then bursts of random items, scored by typed rows or an in-bench image.
// Depends on dicd_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb_top;
  import dicd_pkg::*;

  localparam int IMAGE_WORDS = 254;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS = 26;

  // opcodes the block drops without a result
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // one row of the directed table; typed rows carry their single result
  typedef struct packed {
    logic [2:0]  op;
    logic [12:0] ch;
    logic [31:0] bits;
    logic        typed;
    logic [1:0]  kind;
    logic [12:0] ech;
    logic        bv;
  } dir_row_t;

  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{OP_RD,    13'd1,    32'h0000_0000, 1'b1, KIND_READ,  13'd1,    1'b0},
    '{OP_RD,    13'd8128, 32'h0000_0000, 1'b1, KIND_READ,  13'd8128, 1'b0},
    '{OP_RD,    13'd0,    32'h0000_0000, 1'b1, KIND_RANGE, 13'd0,    1'b0},
    '{OP_RD,    13'd8129, 32'h0000_0000, 1'b1, KIND_RANGE, 13'd0,    1'b0},
    '{OP_RD,    13'd8191, 32'hffff_ffff, 1'b1, KIND_RANGE, 13'd0,    1'b0},
    '{OP_WR1,   13'd1024, 32'hffff_ffff, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR1,   13'd1025, 32'h0000_0001, 1'b1, KIND_RANGE, 13'd0,    1'b0},
    '{OP_WR8,   13'd2032, 32'h0000_00ff, 1'b1, KIND_ALIGN, 13'd0,    1'b0},
    '{OP_WR8,   13'd2033, 32'h0000_00ff, 1'b1, KIND_RANGE, 13'd0,    1'b0},
    '{OP_WR8,   13'd2025, 32'h0000_00a5, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR16,  13'd4049, 32'h0000_ffff, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR16,  13'd4065, 32'h0000_ffff, 1'b1, KIND_RANGE, 13'd0,    1'b0},
    '{OP_WR16,  13'd9,    32'h0000_ffff, 1'b1, KIND_ALIGN, 13'd0,    1'b0},
    '{OP_WR32,  13'd8097, 32'hffff_ffff, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR32,  13'd8097, 32'h0000_0000, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR32,  13'd33,   32'h8000_0001, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR32,  13'd2,    32'hffff_ffff, 1'b1, KIND_ALIGN, 13'd0,    1'b0},
    '{OP_WR32,  13'd0,    32'hffff_ffff, 1'b1, KIND_RANGE, 13'd0,    1'b0},
    '{OP_WR32,  13'd1,    32'h0000_0000, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_RSVD5, 13'd8191, 32'hffff_ffff, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_RSVD6, 13'd1,    32'h0000_0001, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_RSVD7, 13'd0,    32'h0000_0000, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_RD,    13'd1024, 32'h0000_0000, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR8,   13'd1,    32'hffff_ff5a, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR16,  13'd17,   32'h0000_1234, 1'b0, KIND_EVENT, 13'd0,    1'b0},
    '{OP_WR1,   13'd1,    32'hffff_fffe, 1'b0, KIND_EVENT, 13'd0,    1'b0}
  };

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // bench copy of the channel image and the results still owed
  logic [31:0] image_words [0:IMAGE_WORDS-1];
  out_item_t   pending_events [$];
  int          error_count;
  int          cycle_count;
  int          burst_left;

  digital_input_change_detector #(
    .IMAGE_WORDS(IMAGE_WORDS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int unsigned access_width(logic [2:0] op);
    case (op)
      OP_WR8:  return 8;
      OP_WR1:  return 1;
      OP_WR16: return 16;
      OP_WR32: return 32;
      OP_RD:   return 1;
      default: return 0;
    endcase
  endfunction

  // highest legal channel, capped at the image size
  function automatic int unsigned access_limit(logic [2:0] op);
    int unsigned lim;
    case (op)
      OP_WR8:  lim = 32'(LIMIT_WR8);
      OP_WR1:  lim = 32'(LIMIT_WR1);
      OP_WR16: lim = 32'(LIMIT_WR16);
      OP_WR32: lim = 32'(LIMIT_WR32);
      OP_RD:   lim = 32'(LIMIT_RD);
      default: lim = 0;
    endcase
    if (lim > 32 * IMAGE_WORDS)
      lim = 32 * IMAGE_WORDS;
    return lim;
  endfunction

  function automatic out_item_t make_result(logic [1:0] kind, int unsigned ch, logic bv,
                                            logic lst);
    out_item_t r;
    r.kind          = kind;
    r.event_channel = ch[12:0];
    r.bit_value     = bv;
    r.last          = lst;
    return r;
  endfunction

  // update the image for one accepted item and queue the results it owes
  function automatic void predict_changes(in_item_t it);
    int unsigned width, limit, ch, word, sh, lastk;
    logic [31:0] fmask, v, chg;
    width = access_width(it.opcode);
    if (width == 0)
      return;
    limit = access_limit(it.opcode);
    ch = 32'(it.channel);
    if (ch < 1 || ch > limit) begin
      pending_events.push_back(make_result(KIND_RANGE, 0, 1'b0, 1'b1));
      return;
    end
    if (((ch - 1) % width) != 0) begin
      pending_events.push_back(make_result(KIND_ALIGN, 0, 1'b0, 1'b1));
      return;
    end
    word = (ch - 1) / 32;
    sh = (ch - 1) % 32;
    if (it.opcode == OP_RD) begin
      pending_events.push_back(make_result(KIND_READ, ch, image_words[word][sh], 1'b1));
      return;
    end
    fmask = (width == 32) ? 32'hffff_ffff : ((32'd1 << width) - 32'd1);
    v = it.new_bits & fmask;
    chg = ((image_words[word] >> sh) & fmask) ^ v;
    image_words[word] = (image_words[word] & ~(fmask << sh)) | (v << sh);
    lastk = 0;
    for (int k = 0; k < width; k++)
      if (chg[k])
        lastk = k;
    for (int k = 0; k < width; k++)
      if (chg[k])
        pending_events.push_back(make_result(KIND_EVENT, ch + k, v[k], k == lastk));
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (typed)
      pending_events.push_back(typed_res);
    else
      predict_changes(it);
  endtask

  // sender bursts with idle gaps in between
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0)
      return;
    gap = $urandom_range(1, 6);
    @(negedge clk);
    start <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // random item: mostly legal accesses near the busy end of the image
  task automatic make_random_item(output in_item_t it, output bit counted);
    int unsigned width, limit, n, hot_n, idx, ch, word, sh, sel;
    logic [31:0] cur;
    it.new_bits = $urandom();
    counted = 1'b1;
    if ($urandom_range(0, 99) < 4) begin
      case ($urandom_range(0, 2))
        0:       it.opcode = OP_RSVD5;
        1:       it.opcode = OP_RSVD6;
        default: it.opcode = OP_RSVD7;
      endcase
      it.channel = 13'($urandom_range(0, 8191));
      counted = 1'b0;
      return;
    end
    case ($urandom_range(0, 4))
      0:       it.opcode = OP_WR8;
      1:       it.opcode = OP_WR1;
      2:       it.opcode = OP_WR16;
      3:       it.opcode = OP_WR32;
      default: it.opcode = OP_RD;
    endcase
    width = access_width(it.opcode);
    limit = access_limit(it.opcode);
    n = limit / width;
    hot_n = 128 / width;
    if (hot_n > n)
      hot_n = n;
    sel = $urandom_range(0, 99);
    if (sel < 55)
      idx = $urandom_range(0, hot_n - 1);
    else if (sel < 65)
      idx = n - 1 - $urandom_range(0, 3);
    else
      idx = $urandom_range(0, n - 1);
    ch = idx * width + 1;
    sel = $urandom_range(0, 99);
    if (sel < 7) begin
      ch = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(limit + 1, 8191);
    end else if (sel < 14 && width > 1) begin
      ch = ch + $urandom_range(1, width - 1);
    end else begin
      // new levels against the current image
      word = (ch - 1) / 32;
      sh = (ch - 1) % 32;
      cur = image_words[word] >> sh;
      sel = $urandom_range(0, 99);
      if (sel < 20)
        it.new_bits = cur ^ (32'd1 << $urandom_range(0, width - 1));
      else if (sel < 35)
        it.new_bits = cur;
      else if (sel < 50)
        it.new_bits = ~cur;
    end
    it.channel = ch[12:0];
  endtask

  // score every result the block sends
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: kind %0d channel %0d bit %0d last %0d",
               out_item.kind, out_item.event_channel, out_item.bit_value, out_item.last);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_item.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
          error_count++;
        end
        if (out_item.event_channel !== want.event_channel) begin
          $error("event_channel: expected %0d, got %0d", want.event_channel,
                 out_item.event_channel);
          error_count++;
        end
        if (out_item.bit_value !== want.bit_value) begin
          $error("bit_value: expected %0d, got %0d", want.bit_value, out_item.bit_value);
          error_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    in_item_t  it;
    out_item_t typed_res;
    bit        counted;
    int        random_done;
    error_count = 0;
    cycle_count = 0;
    burst_left  = 0;
    random_done = 0;
    for (int w = 0; w < IMAGE_WORDS; w++)
      image_words[w] = 32'd0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.opcode   = dir_table[i].op;
      it.channel  = dir_table[i].ch;
      it.new_bits = dir_table[i].bits;
      typed_res   = make_result(dir_table[i].kind, 32'(dir_table[i].ech), dir_table[i].bv,
                                1'b1);
      send_item(it, dir_table[i].typed, typed_res);
      pace_sender();
    end

    // random items
    while (random_done < RANDOM_ITEMS) begin
      make_random_item(it, counted);
      send_item(it, 1'b0, typed_res);
      if (counted)
        random_done++;
      pace_sender();
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_events.size() != 0) begin
      $error("%0d results never arrived", pending_events.size());
      error_count++;
    end
    if (error_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
